// ----- rtl/thumb_shift_execute_unit_core_assert.svh -----
// Assertion helpers for the shift execute unit.
`ifndef THUMB_SHIFT_EXECUTE_UNIT_CORE_ASSERT_SVH
`define THUMB_SHIFT_EXECUTE_UNIT_CORE_ASSERT_SVH

// Clocked on clk_i, quiet while rst_ni is low.
`define TSEU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Same-cycle implication.
`define TSEU_ASSERT_IMP(label, ante, cons, msg) \
  `TSEU_ASSERT(label, (ante) |-> (cons), msg)

// Next-cycle implication.
`define TSEU_ASSERT_NXT(label, ante, cons, msg) \
  `TSEU_ASSERT(label, (ante) |=> (cons), msg)

`endif

// ----- rtl/tseu_pkg.sv -----
`default_nettype none

package tseu_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned RegNum  = 16;
  localparam int unsigned RegIdxW = 4;

  // Registers that T2 forms may not name as source or destination
  localparam logic [RegIdxW-1:0] RegSp = 4'd13;
  localparam logic [RegIdxW-1:0] RegPc = 4'd15;

  typedef enum logic [2:0] {
    REQ_LOAD       = 3'd0,
    REQ_LSL_IMM_T1 = 3'd1,
    REQ_LSL_REG_T1 = 3'd2,
    REQ_LSR_IMM_T1 = 3'd3,
    REQ_ASR_IMM_T2 = 3'd4,
    REQ_LSL_IMM_T2 = 3'd5
  } req_type_e;

  // Item held between the register file read and the execute step.
  typedef struct packed {
    logic [2:0]         req_type;
    logic [DataW-1:0]   instr;
    logic [RegIdxW-1:0] load_reg;
    logic [DataW-1:0]   load_value;
    logic               in_it;
    logic [RegIdxW-1:0] addr_a;
    logic [RegIdxW-1:0] addr_b;
  } s1_t;

  // Logical left shift by 0..255, returns {carry, result}.
  function automatic logic [DataW:0] shl_c(input logic [DataW-1:0] v,
                                           input logic [7:0] n,
                                           input logic cin);
    logic [DataW:0] t;
    t = {1'b0, v} << n[5:0];
    if (n == 8'd0) begin
      return {cin, v};
    end else if (n > 8'd32) begin
      return '0;
    end
    return t;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/tseu_ram.sv -----
`default_nettype none

module tseu_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];  // read-before-write
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/thumb_shift_execute_unit_core.sv -----
// Path: a registered register file read, then execute into the output register.
// Throughput: one item per cycle while the output is not stalled; the register
//   file sits in two mirrored 16x32 RAMs, one read port each, so LSLS by
//   register reads Rd and Rs at once.
// Reset (rst_ni low, async): flags, per-entry valid bits, forwarding and
//   handshake state clear; entries never written read as zero.
`default_nettype none

`include "thumb_shift_execute_unit_core_assert.svh"

module thumb_shift_execute_unit_core
  import tseu_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // instr_word[31:0], load_reg[35:32], load_value[67:36], zero [71:68]
  input  wire logic [71:0] s_axis_tdata,
  // req_type[2:0], in_it_block[3]
  input  wire logic [3:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // result_value[31:0], dest_reg[35:32], flags_nzcv[39:36]
  output logic      [39:0] m_axis_tdata,
  // reg_written[0], bad_register[1]
  output logic      [1:0]  m_axis_tuser
);

  // ---------------------------------------------------------------
  // Handshake / pipeline control
  // ---------------------------------------------------------------
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic s1_adv;
  logic in_acc;

  s1_t s1_q, s1_d;

  // Stage 1 moves on when the output register is empty or drained this cycle.
  assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------
  // Read address decode at accept
  // ---------------------------------------------------------------
  logic [2:0]         in_type;
  logic [DataW-1:0]   in_instr;
  logic [RegIdxW-1:0] rd_addr_a, rd_addr_b;

  assign in_type  = s_axis_tuser[2:0];
  assign in_instr = s_axis_tdata[31:0];

  always_comb begin
    // Port A: shifted operand Rm, or the shift amount Rs for the by-register form.
    if (in_type == REQ_ASR_IMM_T2 || in_type == REQ_LSL_IMM_T2) begin
      rd_addr_a = in_instr[3:0];
    end else begin
      rd_addr_a = {1'b0, in_instr[5:3]};
    end
    // Port B: Rd for LSLS by register.
    rd_addr_b = {1'b0, in_instr[2:0]};
  end

  always_comb begin
    s1_d.req_type   = in_type;
    s1_d.instr      = in_instr;
    s1_d.load_reg   = s_axis_tdata[35:32];
    s1_d.load_value = s_axis_tdata[67:36];
    s1_d.in_it      = s_axis_tuser[3];
    s1_d.addr_a     = rd_addr_a;
    s1_d.addr_b     = rd_addr_b;
  end

  assign s1_valid_d = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= s1_d;
    end
  end

  // ---------------------------------------------------------------
  // Register file: mirrored RAMs, valid bits, last-write forwarding
  // ---------------------------------------------------------------
  logic               wr_en;
  logic [RegIdxW-1:0] wr_addr;
  logic [DataW-1:0]   wr_data;
  logic [DataW-1:0]   ram_a_rdata, ram_b_rdata;

  tseu_ram #(
    .Width (DataW),
    .Depth (RegNum)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (in_acc),
    .raddr_i (rd_addr_a),
    .rdata_o (ram_a_rdata)
  );

  tseu_ram #(
    .Width (DataW),
    .Depth (RegNum)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (in_acc),
    .raddr_i (rd_addr_b),
    .rdata_o (ram_b_rdata)
  );

  logic [RegNum-1:0]  vld_q, vld_d;
  logic               fwd_vld_q;
  logic [RegIdxW-1:0] fwd_addr_q;
  logic [DataW-1:0]   fwd_data_q;

  always_comb begin
    vld_d = vld_q;
    if (wr_en) begin
      vld_d[wr_addr] = 1'b1;
    end
  end

  // The forwarding register always holds the most recent write. A read
  // issued in the same edge as that write sees stale RAM data, so the
  // execute step prefers it; older writes are already in the RAM.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      fwd_vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
      if (wr_en) begin
        fwd_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fwd_addr_q <= wr_addr;
      fwd_data_q <= wr_data;
    end
  end

  logic [DataW-1:0] op_a, op_b;

  always_comb begin
    if (fwd_vld_q && fwd_addr_q == s1_q.addr_a) begin
      op_a = fwd_data_q;
    end else if (vld_q[s1_q.addr_a]) begin
      op_a = ram_a_rdata;
    end else begin
      op_a = '0;
    end
    if (fwd_vld_q && fwd_addr_q == s1_q.addr_b) begin
      op_b = fwd_data_q;
    end else if (vld_q[s1_q.addr_b]) begin
      op_b = ram_b_rdata;
    end else begin
      op_b = '0;
    end
  end

  // ---------------------------------------------------------------
  // Execute: shifter and flag logic
  // ---------------------------------------------------------------
  logic [3:0] flags_q, flags_d;

  logic [DataW-1:0]   ex_res;
  logic [RegIdxW-1:0] ex_dest;
  logic               ex_wr, ex_bad, ex_upd, ex_carry;

  always_comb begin
    logic [4:0]         imm_t1, imm_t2;
    logic [RegIdxW-1:0] rd_t2, rm_t2;
    logic [DataW:0]     sh;
    logic               cin;

    imm_t1 = s1_q.instr[10:6];
    imm_t2 = {s1_q.instr[14:12], s1_q.instr[7:6]};
    rd_t2  = s1_q.instr[11:8];
    rm_t2  = s1_q.instr[3:0];
    cin    = flags_q[1];
    sh     = '0;

    ex_res   = '0;
    ex_dest  = '0;
    ex_wr    = 1'b0;
    ex_bad   = 1'b0;
    ex_upd   = 1'b0;
    ex_carry = 1'b0;

    unique case (s1_q.req_type)
      REQ_LOAD: begin
        ex_res  = s1_q.load_value;
        ex_dest = s1_q.load_reg;
        ex_wr   = 1'b1;
      end
      REQ_LSL_IMM_T1, REQ_LSL_REG_T1, REQ_LSR_IMM_T1: begin
        ex_dest = {1'b0, s1_q.instr[2:0]};
        ex_wr   = 1'b1;
        ex_upd  = !s1_q.in_it;
        if (s1_q.req_type == REQ_LSL_IMM_T1) begin
          sh = shl_c(op_a, {3'b000, imm_t1}, cin);
          {ex_carry, ex_res} = sh;
        end else if (s1_q.req_type == REQ_LSL_REG_T1) begin
          // amount is the low byte of Rs, shifting Rd
          sh = shl_c(op_b, op_a[7:0], cin);
          {ex_carry, ex_res} = sh;
        end else if (imm_t1 == 5'd0) begin
          // LSRS #0 encodes a shift by 32
          ex_res   = '0;
          ex_carry = op_a[DataW-1];
        end else begin
          sh       = {op_a, 1'b0} >> imm_t1;
          ex_carry = sh[0];
          ex_res   = sh[DataW:1];
        end
      end
      REQ_ASR_IMM_T2, REQ_LSL_IMM_T2: begin
        ex_dest = rd_t2;
        if (rd_t2 == RegSp || rd_t2 == RegPc || rm_t2 == RegSp || rm_t2 == RegPc) begin
          ex_bad = 1'b1;
        end else begin
          ex_wr  = 1'b1;
          ex_upd = s1_q.instr[20];
          if (s1_q.req_type == REQ_LSL_IMM_T2) begin
            sh = shl_c(op_a, {3'b000, imm_t2}, cin);
            {ex_carry, ex_res} = sh;
          end else if (imm_t2 == 5'd0) begin
            // ASR #0 encodes a shift by 32
            ex_res   = {DataW{op_a[DataW-1]}};
            ex_carry = op_a[DataW-1];
          end else begin
            sh       = $unsigned($signed({op_a, 1'b0}) >>> imm_t2);
            ex_carry = sh[0];
            ex_res   = sh[DataW:1];
          end
        end
      end
      default: begin
        // unused request codes leave everything alone
      end
    endcase
  end

  always_comb begin
    flags_d = flags_q;
    if (s1_adv && ex_upd) begin
      flags_d = {ex_res[DataW-1], ex_res == '0, ex_carry, flags_q[0]};  // V kept
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_d;
    end
  end

  assign wr_en   = s1_adv && ex_wr;
  assign wr_addr = ex_dest;
  assign wr_data = ex_res;

  // ---------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------
  logic [39:0] out_data_q;
  logic [1:0]  out_user_q;

  assign out_valid_d = s1_adv ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_data_q <= {flags_d, ex_dest, ex_res};
      out_user_q <= {ex_bad, ex_wr};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  `TSEU_ASSERT_IMP(a_s1_stall_cause, s1_valid_q && !s1_adv,
                   out_valid_q && !m_axis_tready, "stage 1 stalled without backpressure")
  `TSEU_ASSERT_IMP(a_bad_no_write, m_axis_tvalid && m_axis_tuser[1],
                   !m_axis_tuser[0] && m_axis_tdata[31:0] == 32'd0,
                   "bad register item wrote or carried a value")
  `TSEU_ASSERT_NXT(a_write_marks_valid, wr_en,
                   vld_q[$past(wr_addr)] && fwd_vld_q && fwd_addr_q == $past(wr_addr),
                   "register write not tracked")
  `TSEU_ASSERT_NXT(a_v_flag_kept, s1_adv, flags_q[0] == $past(flags_q[0]),
                   "V flag changed")

endmodule

`default_nettype wire
